// ===== sv/agent_grid_trail_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the agent grid and trail engine
// Shorthands for clocked checks that are disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef AGENT_GRID_TRAIL_ENGINE_MACROS_SVH
`define AGENT_GRID_TRAIL_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AGTE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AGTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/agte_pkg.sv =====
// ----------------------------------------------------------------------------
// agte_pkg
// Shared types and constants of the agent grid and trail engine.
// ----------------------------------------------------------------------------
`default_nettype none

package agte_pkg;

  localparam int KIND_W  = 3;
  localparam int COORD_W = 16;
  localparam int TRAIL_W = 8;
  localparam int CFG_W   = 9;

  localparam int TRAIL_MAX = 255;

  localparam logic [CFG_W-1:0] GRID_RESET = 9'd256;

  // Operation codes carried by an item.
  localparam logic [KIND_W-1:0] KIND_PLACE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MOVE     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_VALIDATE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SENSE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEPOSIT  = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_DST,
    ST_EXEC,
    ST_WR_DST
  } state_t;

  typedef struct packed {
    logic clear;
    logic idle;
    logic rd_dst;
    logic exec_fire;
    logic wr_dst;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== sv/agte_ram.sv =====
// ----------------------------------------------------------------------------
// agte_ram
// Single-clock memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module agte_ram #(
  parameter int DEPTH  = 65536,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/agte_seq.sv =====
// ----------------------------------------------------------------------------
// agte_seq
// Sequencer: clearing pass after reset, then read, decide and write back.
// ----------------------------------------------------------------------------
`default_nettype none

module agte_seq import agte_pkg::*; #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              out_free,
  input  wire logic              move_ok,
  output ctrl_t                  ctrl,
  output logic      [ADDR_W-1:0] clr_addr
);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              clr_last;

  assign clr_last = (clr_addr_r == ADDR_W'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    if (state_r == ST_CLEAR) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  state_nxt = clr_last ? ST_IDLE : ST_CLEAR;
      ST_IDLE:   state_nxt = in_valid ? ST_RD_DST : ST_IDLE;
      ST_RD_DST: state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = move_ok ? ST_WR_DST : ST_IDLE;
        end
      end
      ST_WR_DST: state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      ST_CLEAR:  ctrl.clear     = 1'b1;
      ST_IDLE:   ctrl.idle      = 1'b1;
      ST_RD_DST: ctrl.rd_dst    = 1'b1;
      ST_EXEC:   ctrl.exec_fire = out_free;
      ST_WR_DST: ctrl.wr_dst    = 1'b1;
      default:   ctrl           = '0;
    endcase
  end

  assign clr_addr = clr_addr_r;

endmodule

`default_nettype wire

// ===== sv/agent_grid_trail_engine.sv =====
// ----------------------------------------------------------------------------
// agent_grid_trail_engine
// Occupancy bit grid and 8-bit trail grid serving one operation per item.
// ----------------------------------------------------------------------------
// An item on the in_ channel (valid/stall) carries an operation: place, move,
// validate, sense or deposit. Each item gives exactly one result on the out_
// channel (valid/stall): ok and trail_level. The user is to write the grid
// bounds on the cfg_ channel (valid/ready, always ready) only while the block
// is idle; the block does not enforce it. Both grids live in agte_ram memories
// (one write port, one registered read port). The source cell is read in the
// accept cycle, the destination in the next; the result is decided, written
// back and put in the output register once that register is free. A new item
// is taken only after the previous one is written back; a successful move
// adds the ST_WR_DST write, as the occupancy memory has one write port and a
// move writes two cells. Accesses never overlap, so no forwarding is needed.
// A stalled receiver delays the write-back of the following item, not its
// acceptance. After reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells
// zeroes both grids; in_stall stays high meanwhile, cfg writes are taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "agent_grid_trail_engine_macros.svh"

module agent_grid_trail_engine import agte_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [KIND_W-1:0]  in_kind,
  input  wire logic [COORD_W-1:0] in_pos_x,
  input  wire logic [COORD_W-1:0] in_pos_y,
  input  wire logic [COORD_W-1:0] in_dest_x,
  input  wire logic [COORD_W-1:0] in_dest_y,
  input  wire logic [TRAIL_W-1:0] in_amount,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_ok,
  output logic      [TRAIL_W-1:0] out_trail_level,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);

  ctrl_t ctrl;
  logic [ADDR_W-1:0] clr_addr;

  // Configuration.
  logic [CFG_W-1:0]   grid_width_r, grid_height_r;
  logic [COORD_W-1:0] act_w, act_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_RESET;
      grid_height_r <= GRID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_data;
        default:         grid_width_r  <= grid_width_r;
      endcase
    end
  end

  assign act_w = (32'(grid_width_r) > MAX_WIDTH) ? COORD_W'(MAX_WIDTH)
                                                  : COORD_W'(grid_width_r);
  assign act_h = (32'(grid_height_r) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT)
                                                    : COORD_W'(grid_height_r);

  // Bounds and cell addresses of the incoming item.
  logic              accept;
  logic              src_ib, dst_ib;
  logic [ADDR_W-1:0] src_addr, dst_addr;

  assign accept = in_valid && !in_stall;
  assign src_ib = (in_pos_x < act_w) && (in_pos_y < act_h);
  assign dst_ib = (in_dest_x < act_w) && (in_dest_y < act_h);

  // Cell (x, y) sits at y * MAX_WIDTH + x; only meaningful when in bounds.
  assign src_addr = ADDR_W'(in_pos_y[YW-1:0]) * ADDR_W'(MAX_WIDTH)
                  + ADDR_W'(in_pos_x[XW-1:0]);
  assign dst_addr = ADDR_W'(in_dest_y[YW-1:0]) * ADDR_W'(MAX_WIDTH)
                  + ADDR_W'(in_dest_x[XW-1:0]);

  logic [KIND_W-1:0]  kind_r;
  logic [TRAIL_W-1:0] amount_r;
  logic [ADDR_W-1:0]  src_addr_r, dst_addr_r;
  logic               src_ib_r, dst_ib_r;
  logic               src_occ_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r     <= in_kind;
      amount_r   <= in_amount;
      src_addr_r <= src_addr;
      dst_addr_r <= dst_addr;
      src_ib_r   <= src_ib;
      dst_ib_r   <= dst_ib;
    end
  end

  // Memories.
  logic              occ_we, occ_wdata, occ_re, occ_rdata;
  logic [ADDR_W-1:0] occ_waddr, occ_raddr;
  logic              trail_we;
  logic [ADDR_W-1:0] trail_waddr;
  logic [TRAIL_W-1:0] trail_wdata, trail_rdata;

  agte_ram #(
    .DEPTH  (DEPTH),
    .WIDTH  (1),
    .ADDR_W (ADDR_W)
  ) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .re    (occ_re),
    .raddr (occ_raddr),
    .rdata (occ_rdata)
  );

  agte_ram #(
    .DEPTH  (DEPTH),
    .WIDTH  (TRAIL_W),
    .ADDR_W (ADDR_W)
  ) u_trail_ram (
    .clk   (clk),
    .we    (trail_we),
    .waddr (trail_waddr),
    .wdata (trail_wdata),
    .re    (accept),
    .raddr (src_addr),
    .rdata (trail_rdata)
  );

  // The source occupancy comes back in the cycle the destination is read.
  always_ff @(posedge clk) begin
    if (ctrl.rd_dst) begin
      src_occ_r <= occ_rdata;
    end
  end

  assign occ_re    = accept || ctrl.rd_dst;
  assign occ_raddr = ctrl.rd_dst ? dst_addr_r : src_addr;

  // Decision, valid in the write-back cycle.
  logic               move_chk, move_ok, ok_c;
  logic [TRAIL_W:0]   dep_sum;
  logic [TRAIL_W-1:0] level_c;
  logic               out_free;

  assign move_chk = src_ib_r && src_occ_r && dst_ib_r && !occ_rdata;
  assign move_ok  = (kind_r == KIND_MOVE) && move_chk;
  assign dep_sum  = {1'b0, trail_rdata} + {1'b0, amount_r};

  always_comb begin
    ok_c    = 1'b0;
    level_c = '0;
    unique case (kind_r)
      KIND_PLACE:    ok_c = src_ib_r && !src_occ_r;
      KIND_MOVE:     ok_c = move_chk;
      KIND_VALIDATE: ok_c = move_chk;
      KIND_SENSE:    level_c = src_ib_r ? trail_rdata : '0;
      KIND_DEPOSIT:  ok_c = src_ib_r && (dep_sum <= (TRAIL_W + 1)'(TRAIL_MAX));
      default:       ok_c = 1'b0;
    endcase
  end

  // Write-back.
  always_comb begin
    occ_we    = 1'b0;
    occ_waddr = src_addr_r;
    occ_wdata = 1'b0;
    priority if (ctrl.clear) begin
      occ_we    = 1'b1;
      occ_waddr = clr_addr;
    end else if (ctrl.wr_dst) begin
      occ_we    = 1'b1;
      occ_waddr = dst_addr_r;
      occ_wdata = 1'b1;
    end else if (ctrl.exec_fire) begin
      occ_we    = ok_c && ((kind_r == KIND_PLACE) || (kind_r == KIND_MOVE));
      occ_wdata = (kind_r == KIND_PLACE);
    end else begin
      occ_we    = 1'b0;
    end
  end

  assign trail_we    = ctrl.clear ||
                       (ctrl.exec_fire && ok_c && (kind_r == KIND_DEPOSIT));
  assign trail_waddr = ctrl.clear ? clr_addr : src_addr_r;
  assign trail_wdata = ctrl.clear ? '0 : dep_sum[TRAIL_W-1:0];

  // Output register.
  logic               out_valid_r;
  logic               out_ok_r;
  logic [TRAIL_W-1:0] out_trail_level_r;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec_fire) begin
      out_ok_r          <= ok_c;
      out_trail_level_r <= level_c;
    end
  end

  agte_seq #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .move_ok  (move_ok),
    .ctrl     (ctrl),
    .clr_addr (clr_addr)
  );

  assign in_stall        = !ctrl.idle;
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_trail_level = out_trail_level_r;

  // Checks.
  `AGTE_ASSERT_NEXT(a_accept_reads_dst, accept, ctrl.rd_dst, "accept not followed by dst read")
  `AGTE_ASSERT_SAME(a_wr_dst_after_move, ctrl.wr_dst, $past(ctrl.exec_fire && move_ok), "dst write without a successful move")
  `AGTE_ASSERT_SAME(a_dual_write_clear, occ_we && trail_we, ctrl.clear, "both grids written outside the clearing pass")
  `AGTE_ASSERT_NEXT(a_exec_gives_result, ctrl.exec_fire, out_valid_r, "write-back did not present a result")

endmodule

`default_nettype wire
